### rtl/gal_pkg.sv
// ----------------------------------------------------------------------------
// gal_pkg
// Shared types and field widths of the grouped leaf allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gal_pkg;

   localparam int OP_W        = 2;
   localparam int GROUP_ID_W  = 8;
   localparam int OFF_W       = 16;
   localparam int STATUS_W    = 2;
   localparam int OUT_GROUP_W = 7;
   localparam int COUNT_W     = 5;
   localparam int TOTAL_W     = 11;
   // group numbers compared against the open-group mark, one bit above the id
   localparam int GCMP_W      = GROUP_ID_W + 1;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC     = 2'd0,
      OP_FREE      = 2'd1,
      OP_QUERY     = 2'd2,
      OP_SET_START = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_NO_SPACE = 2'd1,
      ST_BAD_LEAF = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_CHECK,
      S_OPEN,
      S_POP_RD,
      S_POP,
      S_POP_CNT,
      S_LOOK,
      S_FINISH
   } state_type;

endpackage

`default_nettype wire

### rtl/gal_ram.sv
// ----------------------------------------------------------------------------
// gal_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gal_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/grouped_leaf_allocator.sv
// ----------------------------------------------------------------------------
// grouped_leaf_allocator
// Slab allocator for fixed-size leaves kept in groups, with a LIFO free stack,
// a used bit per leaf and a used count per group, all held in RAM.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req_    | in  | req_valid/req_ready  | op, group_id, leaf_offset
//  rsp_    | out | rsp_valid/rsp_ready  | status, pointer, leaf flags, counts, start
//
//  One item at a time. Free, query, set-start and a failed allocate step through
//  S_DIV, S_CHECK, S_LOOK and S_FINISH, which loads the result; an allocate that
//  pops the stack steps through S_DIV, S_CHECK, S_POP_RD, S_POP and S_POP_CNT, and
//  one that opens a group first pushes its leaves in S_OPEN (one stack write per
//  cycle). The next item is accepted the cycle after the result loads.
//  No clearing pass after reset: a group's used bits and count are zeroed by
//  the pushes that open it, and groups not yet open never use their RAM contents.
//  The result register frees the request side; a held result stalls only the
//  final step of the following item.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_leaf_allocator #(
   parameter int LEAVES_PER_GROUP = 16,
   parameter int MAX_GROUPS       = 64,
   parameter int LEAF_BYTES       = 256,
   parameter int HEAD_BYTES       = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [gal_pkg::OP_W-1:0]          req_op,
   input  wire logic [gal_pkg::GROUP_ID_W-1:0]    req_group_id,
   input  wire logic [gal_pkg::OFF_W-1:0]         req_leaf_offset,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [gal_pkg::STATUS_W-1:0]           rsp_status,
   output logic [gal_pkg::OUT_GROUP_W-1:0]        rsp_out_group,
   output logic [gal_pkg::OFF_W-1:0]              rsp_out_offset,
   output logic                                   rsp_leaf_exists,
   output logic                                   rsp_leaf_used,
   output logic                                   rsp_leaf_free,
   output logic [gal_pkg::COUNT_W-1:0]            rsp_group_used_count,
   output logic [gal_pkg::TOTAL_W-1:0]            rsp_free_total,
   output logic [gal_pkg::OUT_GROUP_W-1:0]        rsp_start_group_out,
   output logic [gal_pkg::OFF_W-1:0]              rsp_start_offset_out
);

   localparam int TOTAL = MAX_GROUPS * LEAVES_PER_GROUP;
   localparam int IW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam int FW    = $clog2(TOTAL + 1);
   localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
   localparam int SW    = (LEAVES_PER_GROUP > 1) ? $clog2(LEAVES_PER_GROUP) : 1;
   localparam int EW    = GW + SW;
   localparam int CW    = $clog2(LEAVES_PER_GROUP + 1);
   localparam int NGW   = $clog2(MAX_GROUPS + 2);
   localparam int OW    = gal_pkg::OFF_W;
   localparam int GCW   = gal_pkg::GCMP_W;
   // exact floor(d / LEAF_BYTES) for 16-bit d: (d * RECIP) >> RSH
   localparam int RSH   = OW + $clog2(LEAF_BYTES);
   localparam longint unsigned RECIP_L =
      ((64'd1 << RSH) + 64'(LEAF_BYTES) - 64'd1) / 64'(LEAF_BYTES);
   localparam logic [OW:0] RECIP = (OW+1)'(RECIP_L);

   function automatic logic [IW-1:0] leaf_idx(input logic [GW-1:0] gm1,
                                              input logic [SW-1:0] slot);
      return IW'(32'(gm1) * LEAVES_PER_GROUP + 32'(slot));
   endfunction

   // registers
   gal_pkg::state_type              state_ff, state_in;
   gal_pkg::op_type                 op_ff, op_in;
   logic [gal_pkg::GROUP_ID_W-1:0]  g_ff, g_in;
   logic [OW-1:0]                   off_ff, off_in;
   logic                            below_ff, below_in;
   logic [OW-1:0]                   d_ff, d_in;
   logic [OW-1:0]                   q_ff, q_in;
   logic                            ex_ff, ex_in;
   logic [SW-1:0]                   slot_ff, slot_in;
   logic [IW-1:0]                   idx_ff, idx_in;
   logic [FW-1:0]                   fc_ff, fc_in;
   logic [NGW-1:0]                  ng_ff, ng_in;
   logic [SW-1:0]                   open_ff, open_in;
   logic [GW-1:0]                   pop_g_ff, pop_g_in;
   logic [SW-1:0]                   pop_slot_ff, pop_slot_in;
   logic [gal_pkg::GROUP_ID_W-1:0]  start_group_ff, start_group_in;
   logic [OW-1:0]                   start_offset_ff, start_offset_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   gal_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [gal_pkg::OUT_GROUP_W-1:0] rsp_group_ff, rsp_group_in;
   logic [OW-1:0]                   rsp_offset_ff, rsp_offset_in;
   logic                            rsp_exists_ff, rsp_exists_in;
   logic                            rsp_used_ff, rsp_used_in;
   logic                            rsp_free_ff, rsp_free_in;
   logic [gal_pkg::COUNT_W-1:0]     rsp_count_ff, rsp_count_in;
   logic [gal_pkg::TOTAL_W-1:0]     rsp_total_ff, rsp_total_in;
   logic [gal_pkg::OUT_GROUP_W-1:0] rsp_sgroup_ff, rsp_sgroup_in;
   logic [OW-1:0]                   rsp_soffset_ff, rsp_soffset_in;

   // RAM ports
   logic           stack_we;
   logic [IW-1:0]  stack_wr_addr, stack_rd_addr;
   logic [EW-1:0]  stack_wr_data, stack_rd_data;
   logic           used_we;
   logic [IW-1:0]  used_wr_addr, used_rd_addr;
   logic           used_wr_data, used_rd_data;
   logic           cnt_we;
   logic [GW-1:0]  cnt_wr_addr, cnt_rd_addr;
   logic [CW-1:0]  cnt_wr_data, cnt_rd_data;

   logic           out_free;
   logic           open_last;
   logic           fail_full;

   gal_ram #(.WIDTH(EW), .DEPTH(TOTAL), .ADDR_W(IW)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_wr_addr),
      .wr_data (stack_wr_data),
      .rd_addr (stack_rd_addr),
      .rd_data (stack_rd_data)
   );

   gal_ram #(.WIDTH(1), .DEPTH(TOTAL), .ADDR_W(IW)) u_used_ram (
      .clock   (clock),
      .wr_en   (used_we),
      .wr_addr (used_wr_addr),
      .wr_data (used_wr_data),
      .rd_addr (used_rd_addr),
      .rd_data (used_rd_data)
   );

   gal_ram #(.WIDTH(CW), .DEPTH(MAX_GROUPS), .ADDR_W(GW)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign open_last = (open_ff == SW'(LEAVES_PER_GROUP - 1));
   assign fail_full = (GCW'(ng_ff) > GCW'(MAX_GROUPS));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gal_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = gal_pkg::S_DIV;
            end
         end
         gal_pkg::S_DIV: begin
            state_in = gal_pkg::S_CHECK;
         end
         gal_pkg::S_CHECK: begin
            if (op_ff == gal_pkg::OP_ALLOC) begin
               if (fc_ff != '0) begin
                  state_in = gal_pkg::S_POP_RD;
               end else if (fail_full) begin
                  state_in = gal_pkg::S_LOOK;
               end else begin
                  state_in = gal_pkg::S_OPEN;
               end
            end else begin
               state_in = gal_pkg::S_LOOK;
            end
         end
         gal_pkg::S_OPEN: begin
            if (open_last) begin
               state_in = gal_pkg::S_POP_RD;
            end
         end
         gal_pkg::S_POP_RD: begin
            state_in = gal_pkg::S_POP;
         end
         gal_pkg::S_POP: begin
            state_in = gal_pkg::S_POP_CNT;
         end
         gal_pkg::S_POP_CNT: begin
            if (out_free) begin
               state_in = gal_pkg::S_IDLE;
            end
         end
         gal_pkg::S_LOOK: begin
            state_in = gal_pkg::S_FINISH;
         end
         gal_pkg::S_FINISH: begin
            if (out_free) begin
               state_in = gal_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = gal_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      logic [OW-1:0]     d_c;
      logic [2*OW:0]     prod_c;
      logic [31:0]       back_c;
      logic              cnt_ok_c;
      logic [CW-1:0]     cnt_c;
      logic              used_c;
      logic [GW-1:0]     gm1_c;
      logic [GW-1:0]     ng_m1_c;
      logic [GW-1:0]     e_g_c;
      logic [SW-1:0]     e_s_c;
      logic [OW-1:0]     alloc_off_c;

      op_in           = op_ff;
      g_in            = g_ff;
      off_in          = off_ff;
      below_in        = below_ff;
      d_in            = d_ff;
      q_in            = q_ff;
      ex_in           = ex_ff;
      slot_in         = slot_ff;
      idx_in          = idx_ff;
      fc_in           = fc_ff;
      ng_in           = ng_ff;
      open_in         = open_ff;
      pop_g_in        = pop_g_ff;
      pop_slot_in     = pop_slot_ff;
      start_group_in  = start_group_ff;
      start_offset_in = start_offset_ff;

      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_status_in   = rsp_status_ff;
      rsp_group_in    = rsp_group_ff;
      rsp_offset_in   = rsp_offset_ff;
      rsp_exists_in   = rsp_exists_ff;
      rsp_used_in     = rsp_used_ff;
      rsp_free_in     = rsp_free_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_total_in    = rsp_total_ff;
      rsp_sgroup_in   = rsp_sgroup_ff;
      rsp_soffset_in  = rsp_soffset_ff;

      req_ready       = 1'b0;

      d_c         = off_ff - OW'(HEAD_BYTES);
      prod_c      = (2*OW+1)'(d_c) * (2*OW+1)'(RECIP);
      back_c      = 32'(q_ff) * 32'(LEAF_BYTES);
      gm1_c       = GW'(g_ff - 8'd1);
      ng_m1_c     = GW'(ng_ff - NGW'(1));
      e_g_c       = stack_rd_data[EW-1:SW];
      e_s_c       = stack_rd_data[SW-1:0];
      cnt_ok_c    = (g_ff != '0) && (GCW'(g_ff) < GCW'(ng_ff));
      cnt_c       = cnt_ok_c ? cnt_rd_data : '0;
      used_c      = ex_ff && used_rd_data;
      alloc_off_c = OW'(HEAD_BYTES + 32'(pop_slot_ff) * LEAF_BYTES);

      stack_we      = 1'b0;
      stack_wr_addr = IW'(fc_ff);
      stack_wr_data = {gm1_c, slot_ff};
      stack_rd_addr = IW'(fc_ff - FW'(1));
      used_we       = 1'b0;
      used_wr_addr  = idx_ff;
      used_wr_data  = 1'b0;
      used_rd_addr  = idx_ff;
      cnt_we        = 1'b0;
      cnt_wr_addr   = gm1_c;
      cnt_wr_data   = '0;
      cnt_rd_addr   = gm1_c;

      case (state_ff)
         gal_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in  = gal_pkg::op_type'(req_op);
               g_in   = req_group_id;
               off_in = req_leaf_offset;
            end
         end
         gal_pkg::S_DIV: begin
            below_in = (off_ff < OW'(HEAD_BYTES));
            d_in     = d_c;
            q_in     = OW'(prod_c >> RSH);
         end
         gal_pkg::S_CHECK: begin
            ex_in   = cnt_ok_c && !below_ff && (32'(q_ff) < LEAVES_PER_GROUP)
                      && (back_c == 32'(d_ff));
            slot_in = q_ff[SW-1:0];
            idx_in  = leaf_idx(gm1_c, q_ff[SW-1:0]);
         end
         gal_pkg::S_OPEN: begin
            // one push per cycle; the same pass zeroes the group's used state
            stack_we      = 1'b1;
            stack_wr_addr = IW'(fc_ff);
            stack_wr_data = {ng_m1_c, open_ff};
            used_we       = 1'b1;
            used_wr_addr  = leaf_idx(ng_m1_c, open_ff);
            used_wr_data  = 1'b0;
            cnt_we        = 1'b1;
            cnt_wr_addr   = ng_m1_c;
            cnt_wr_data   = '0;
            fc_in         = fc_ff + FW'(1);
            if (open_last) begin
               open_in = '0;
               ng_in   = ng_ff + NGW'(1);
            end else begin
               open_in = open_ff + SW'(1);
            end
         end
         gal_pkg::S_POP_RD: begin
            stack_rd_addr = IW'(fc_ff - FW'(1));
         end
         gal_pkg::S_POP: begin
            fc_in        = fc_ff - FW'(1);
            used_we      = 1'b1;
            used_wr_addr = leaf_idx(e_g_c, e_s_c);
            used_wr_data = 1'b1;
            cnt_rd_addr  = e_g_c;
            pop_g_in     = e_g_c;
            pop_slot_in  = e_s_c;
         end
         gal_pkg::S_POP_CNT: begin
            cnt_rd_addr = pop_g_ff;
            if (out_free) begin
               cnt_we      = 1'b1;
               cnt_wr_addr = pop_g_ff;
               cnt_wr_data = cnt_rd_data + CW'(1);
               if (start_group_ff == '0) begin
                  start_group_in  = gal_pkg::GROUP_ID_W'(32'(pop_g_ff) + 1);
                  start_offset_in = alloc_off_c;
               end
               rsp_valid_in   = 1'b1;
               rsp_status_in  = gal_pkg::ST_OK;
               rsp_group_in   = gal_pkg::OUT_GROUP_W'(32'(pop_g_ff) + 1);
               rsp_offset_in  = alloc_off_c;
               rsp_exists_in  = 1'b1;
               rsp_used_in    = 1'b1;
               rsp_free_in    = 1'b0;
               rsp_count_in   = gal_pkg::COUNT_W'(cnt_rd_data + CW'(1));
               rsp_total_in   = gal_pkg::TOTAL_W'(fc_ff);
               rsp_sgroup_in  = start_group_in[gal_pkg::OUT_GROUP_W-1:0];
               rsp_soffset_in = start_offset_in;
            end
         end
         gal_pkg::S_LOOK: begin
            used_rd_addr = idx_ff;
            cnt_rd_addr  = gm1_c;
         end
         gal_pkg::S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = gal_pkg::ST_OK;
               rsp_group_in  = g_ff[gal_pkg::OUT_GROUP_W-1:0];
               rsp_offset_in = off_ff;
               rsp_exists_in = ex_ff;
               rsp_used_in   = used_c;
               rsp_free_in   = ex_ff && !used_c;
               rsp_count_in  = gal_pkg::COUNT_W'(cnt_c);
               case (op_ff)
                  gal_pkg::OP_ALLOC: begin
                     rsp_status_in = gal_pkg::ST_NO_SPACE;
                  end
                  gal_pkg::OP_FREE: begin
                     if (used_c && (32'(fc_ff) < TOTAL)) begin
                        stack_we      = 1'b1;
                        stack_wr_addr = IW'(fc_ff);
                        stack_wr_data = {gm1_c, slot_ff};
                        used_we       = 1'b1;
                        used_wr_addr  = idx_ff;
                        used_wr_data  = 1'b0;
                        cnt_we        = 1'b1;
                        cnt_wr_addr   = gm1_c;
                        cnt_wr_data   = cnt_rd_data - CW'(1);
                        fc_in         = fc_ff + FW'(1);
                        rsp_used_in   = 1'b0;
                        rsp_free_in   = 1'b1;
                        rsp_count_in  = gal_pkg::COUNT_W'(cnt_rd_data - CW'(1));
                     end else begin
                        rsp_status_in = gal_pkg::ST_BAD_LEAF;
                     end
                  end
                  gal_pkg::OP_QUERY: begin
                     rsp_status_in = gal_pkg::ST_OK;
                  end
                  gal_pkg::OP_SET_START: begin
                     start_group_in  = {1'b0, g_ff[gal_pkg::OUT_GROUP_W-1:0]};
                     start_offset_in = off_ff;
                  end
                  default: begin
                     rsp_status_in = gal_pkg::ST_OK;
                  end
               endcase
               rsp_total_in   = gal_pkg::TOTAL_W'(fc_in);
               rsp_sgroup_in  = start_group_in[gal_pkg::OUT_GROUP_W-1:0];
               rsp_soffset_in = start_offset_in;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= gal_pkg::S_IDLE;
         fc_ff           <= '0;
         ng_ff           <= NGW'(1);
         open_ff         <= '0;
         start_group_ff  <= '0;
         start_offset_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         fc_ff           <= fc_in;
         ng_ff           <= ng_in;
         open_ff         <= open_in;
         start_group_ff  <= start_group_in;
         start_offset_ff <= start_offset_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      g_ff           <= g_in;
      off_ff         <= off_in;
      below_ff       <= below_in;
      d_ff           <= d_in;
      q_ff           <= q_in;
      ex_ff          <= ex_in;
      slot_ff        <= slot_in;
      idx_ff         <= idx_in;
      pop_g_ff       <= pop_g_in;
      pop_slot_ff    <= pop_slot_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_group_ff   <= rsp_group_in;
      rsp_offset_ff  <= rsp_offset_in;
      rsp_exists_ff  <= rsp_exists_in;
      rsp_used_ff    <= rsp_used_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_sgroup_ff  <= rsp_sgroup_in;
      rsp_soffset_ff <= rsp_soffset_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_out_group        = rsp_group_ff;
   assign rsp_out_offset       = rsp_offset_ff;
   assign rsp_leaf_exists      = rsp_exists_ff;
   assign rsp_leaf_used        = rsp_used_ff;
   assign rsp_leaf_free        = rsp_free_ff;
   assign rsp_group_used_count = rsp_count_ff;
   assign rsp_free_total       = rsp_total_ff;
   assign rsp_start_group_out  = rsp_sgroup_ff;
   assign rsp_start_offset_out = rsp_soffset_ff;

   // stack depth bounded by the leaves of all groups
   a_fc_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fc_ff) <= TOTAL)
      else $error("free stack count above capacity");

   a_ng_bound: assert property (@(posedge clock) disable iff (reset)
      (ng_ff != '0) && (32'(ng_ff) <= MAX_GROUPS + 1))
      else $error("open-group mark out of range");

   // a group only opens on an empty stack, so pushes never overflow
   a_open_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gal_pkg::S_OPEN) |-> (32'(fc_ff) < TOTAL))
      else $error("group open overflows free stack");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gal_pkg::S_POP_RD) |-> (fc_ff != '0))
      else $error("pop from empty free stack");

   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!(rsp_used_ff && rsp_free_ff)
                        && ((rsp_used_ff || rsp_free_ff) == rsp_exists_ff)))
      else $error("leaf flags inconsistent");

endmodule

`default_nettype wire
